@@ design/fis_pkg.sv @@
// Shared constants and types for the frame interval statistics block.
// Used by the channel interfaces, the serial arithmetic units and the top level.
package fis_pkg;

    // Field widths.
    localparam int STAMP_W  = 48;
    localparam int IV_W     = 24;
    localparam int CNT_W    = 16;
    localparam int FRAC_W   = 16;
    localparam int MEAN_W   = IV_W + FRAC_W;
    localparam int SPREAD_W = 64;

    // Serial units retire two bits per cycle.
    localparam int DIV_STEPS = MEAN_W / 2;
    localparam int MUL_STEPS = MEAN_W / 2;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    // Configuration port: one 64-bit register at byte address 8*index.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;
    localparam logic REG_WINDOW_TICKS = 1'b0;
    localparam logic [STAMP_W-1:0] WINDOW_TICKS_RST = STAMP_W'(1000000);

    // Registered result, as it is presented on the output channel.
    typedef struct packed {
        logic [IV_W-1:0]     frame_interval;
        logic                window_done;
        logic [CNT_W-1:0]    window_frames;
        logic [STAMP_W-1:0]  window_elapsed;
        logic [MEAN_W-1:0]   mean_interval;
        logic [SPREAD_W-1:0] spread_sum;
        logic [IV_W-1:0]     min_interval;
        logic [IV_W-1:0]     max_interval;
    } t_result;

endpackage

@@ design/fis_stamp_if.sv @@
// Input channel interface: one frame timestamp per request.
// Depends on fis_pkg for the field width.
interface fis_stamp_if import fis_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAMP_W-1:0] timestamp;

    modport source (output valid, output timestamp, input ready);
    modport sink (input valid, input timestamp, output ready);
endinterface

@@ design/fis_result_if.sv @@
// Output channel interface: interval and closed-window statistics per request.
// Depends on fis_pkg for the field widths.
interface fis_result_if import fis_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IV_W-1:0]     frame_interval;
    logic                window_done;
    logic [CNT_W-1:0]    window_frames;
    logic [STAMP_W-1:0]  window_elapsed;
    logic [MEAN_W-1:0]   mean_interval;
    logic [SPREAD_W-1:0] spread_sum;
    logic [IV_W-1:0]     min_interval;
    logic [IV_W-1:0]     max_interval;

    modport source (
        output valid, output frame_interval, output window_done, output window_frames,
        output window_elapsed, output mean_interval, output spread_sum,
        output min_interval, output max_interval, input ready
    );
    modport sink (
        input valid, input frame_interval, input window_done, input window_frames,
        input window_elapsed, input mean_interval, input spread_sum,
        input min_interval, input max_interval, output ready
    );
endinterface

@@ design/fis_div.sv @@
// Radix-4 restoring divider: unsigned mean delta divided by the frame count.
// Two quotient bits per cycle; depends on fis_pkg for widths and step count.
module fis_div import fis_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MEAN_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [MEAN_W-1:0] o_quotient
);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_den;
    logic [MEAN_W-1:0]     r_quo;

    logic [CNT_W:0]   w_t1;
    logic [CNT_W:0]   w_t2;
    logic             w_ge1;
    logic             w_ge2;
    logic [CNT_W-1:0] w_r1;
    logic [CNT_W-1:0] w_r2;

    // Two restoring steps: the remainder always stays below a nonzero divisor.
    always_comb begin
        w_t1  = {r_rem, r_quo[MEAN_W-1]};
        w_ge1 = (w_t1 >= {1'b0, r_den});
        w_r1  = w_ge1 ? CNT_W'(w_t1 - {1'b0, r_den}) : w_t1[CNT_W-1:0];
        w_t2  = {w_r1, r_quo[MEAN_W-2]};
        w_ge2 = (w_t2 >= {1'b0, r_den});
        w_r2  = w_ge2 ? CNT_W'(w_t2 - {1'b0, r_den}) : w_t2[CNT_W-1:0];
    end

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_CNT_W'(DIV_STEPS - 1);
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= w_r2;
                r_quo <= {r_quo[MEAN_W-3:0], w_ge1, w_ge2};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ design/fis_mul.sv @@
// Radix-4 shift-add multiplier for the spread update: (a * b) >> FRAC_W, saturated.
// Two multiplier bits per cycle; depends on fis_pkg for widths and step count.
module fis_mul import fis_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MEAN_W-1:0]   i_a,
    input  logic [MEAN_W-1:0]   i_b,
    output logic                o_done,
    output logic [SPREAD_W-1:0] o_product
);

    localparam int HI_W   = MEAN_W + 2;
    localparam int PROD_W = HI_W + MEAN_W;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [HI_W-1:0]       r_a1;
    logic [HI_W-1:0]       r_a3;
    logic [HI_W-1:0]       r_hi;
    logic [MEAN_W-1:0]     r_lo;

    logic [HI_W-1:0]   w_dm;
    logic [HI_W:0]     w_sum;
    logic [PROD_W-1:0] w_prod;
    logic              w_sat;

    // Partial product for the current digit of the multiplier.
    always_comb begin
        case (r_lo[1:0])
            2'd0:    w_dm = '0;
            2'd1:    w_dm = r_a1;
            2'd2:    w_dm = {r_a1[HI_W-2:0], 1'b0};
            2'd3:    w_dm = r_a3;
            default: w_dm = '0;
        endcase
        w_sum = {1'b0, r_hi} + {1'b0, w_dm};
    end

    // Accumulate into the upper half and shift the running product right.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_CNT_W'(MUL_STEPS - 1);
                r_a1   <= HI_W'(i_a);
                r_a3   <= HI_W'(i_a) + {1'b0, i_a, 1'b0};
                r_hi   <= '0;
                r_lo   <= i_b;
            end else if (r_busy) begin
                r_hi <= HI_W'(w_sum[HI_W:2]);
                r_lo <= {w_sum[1:0], r_lo[MEAN_W-1:2]};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Drop the fraction bits and clamp anything above the result width.
    assign w_prod    = {r_hi, r_lo};
    assign w_sat     = |w_prod[PROD_W-1:FRAC_W+SPREAD_W];
    assign o_product = w_sat ? '1 : w_prod[FRAC_W +: SPREAD_W];
    assign o_done    = r_done;

endmodule

@@ design/frame_interval_statistics.sv @@
// Top level: frame interval and windowed Welford statistics with an APB register.
// Depends on fis_pkg, fis_stamp_if, fis_result_if, fis_div and fis_mul.
//
//   Port        Direction  Carries
//   i_stamp     in         timestamp (valid/ready)
//   o_result    out        interval and closed-window statistics (valid/ready)
//   APB         in/out     window_ticks at byte address 0
//
// The input is ready only in idle, so a request finishes before the next is taken; each
// later one runs the radix-4 serial divider (20 steps) and multiplier (20 steps).
// The first request after reset only primes the timestamps; its result is all zero.
// Reset is synchronous and active low; it restores the statistics and the register.
// A loaded result waits in the output register while the next request is taken; if it
// still waits when the next result is ready, the sequencer holds and the input stalls.
module frame_interval_statistics import fis_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fis_stamp_if.sink             i_stamp,
    fis_result_if.source          o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_DIFF, S_DSTART, S_DIV, S_UPD, S_D2,
        S_MSTART, S_MUL, S_ACC, S_FIN
    } t_state;

    t_state r_state;

    // Configuration and window state.
    logic [STAMP_W-1:0]  r_window_ticks;
    logic                r_primed;
    logic [STAMP_W-1:0]  r_last_stamp;
    logic [STAMP_W-1:0]  r_window_start;
    logic [CNT_W-1:0]    r_frames;
    logic [MEAN_W-1:0]   r_mean;
    logic [SPREAD_W-1:0] r_spread;
    logic [IV_W-1:0]     r_least;
    logic [IV_W-1:0]     r_greatest;

    // Per-request working registers.
    logic [STAMP_W-1:0]  r_ts;
    logic [IV_W-1:0]     r_iv;
    logic [STAMP_W-1:0]  r_elapsed;
    logic                r_close;
    logic                r_neg;
    logic [MEAN_W-1:0]   r_a;
    logic [MEAN_W-1:0]   r_b;
    logic [MEAN_W-1:0]   r_mean_new;

    // Output register.
    logic                r_out_valid;
    t_result             r_out;

    logic                w_accept;
    logic                w_cfg_write;
    logic                w_out_free;
    logic [STAMP_W-1:0]  w_dt;
    logic [IV_W-1:0]     w_iv;
    logic [STAMP_W-1:0]  w_elapsed;
    logic [MEAN_W-1:0]   w_x;
    logic [MEAN_W:0]     w_d;
    logic [MEAN_W:0]     w_d_neg;
    logic [MEAN_W:0]     w_d2;
    logic [MEAN_W:0]     w_d2_neg;
    logic [MEAN_W-1:0]   w_mean_new;
    logic [SPREAD_W:0]   w_spread_sum;
    logic                w_div_done;
    logic [MEAN_W-1:0]   w_quotient;
    logic                w_mul_done;
    logic [SPREAD_W-1:0] w_product;

    assign w_accept    = i_stamp.valid && i_stamp.ready;
    assign w_cfg_write = psel && penable && pwrite && pready
                         && (paddr[CFG_ADDR_W-1] == REG_WINDOW_TICKS);
    assign w_out_free  = !r_out_valid || o_result.ready;

    // Register read-back and an always-ready bus.
    assign pready = 1'b1;
    assign prdata = (paddr[CFG_ADDR_W-1] == REG_WINDOW_TICKS)
                    ? CFG_DATA_W'(r_window_ticks) : '0;

    // Interval, saturated interval and elapsed window time.
    always_comb begin
        w_dt      = r_ts - r_last_stamp;
        w_iv      = (|w_dt[STAMP_W-1:IV_W]) ? '1 : w_dt[IV_W-1:0];
        w_elapsed = r_ts - r_window_start;
    end

    // Signed deltas against the old and the new mean, their negations, the new mean and the spread sum.
    always_comb begin
        w_x        = {r_iv, FRAC_W'(0)};
        w_d        = {1'b0, w_x} - {1'b0, r_mean};
        w_d_neg    = -w_d;
        w_mean_new = r_neg ? (r_mean - w_quotient) : (r_mean + w_quotient);
        w_d2       = {1'b0, w_x} - {1'b0, r_mean_new};
        w_d2_neg   = -w_d2;
        w_spread_sum = {1'b0, r_spread} + {1'b0, w_product};
    end

    fis_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTART),
        .i_dividend (r_a),
        .i_divisor  (r_frames),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    fis_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_MSTART),
        .i_a       (r_a),
        .i_b       (r_b),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    // Sequencer, statistics and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_window_ticks <= WINDOW_TICKS_RST;
            r_primed       <= 1'b0;
            r_last_stamp   <= '0;
            r_window_start <= '0;
            r_frames       <= '0;
            r_mean         <= '0;
            r_spread       <= '0;
            r_least        <= '1;
            r_greatest     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_cfg_write) begin
                r_window_ticks <= pwdata[STAMP_W-1:0];
            end

            // The output register fills from the sequencer and drains on a result request.
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ts <= i_stamp.timestamp;
                        if (r_primed) begin
                            r_state <= S_PREP;
                        end else begin
                            // First frame only primes the stamps; its result is all zero.
                            r_primed       <= 1'b1;
                            r_last_stamp   <= i_stamp.timestamp;
                            r_window_start <= i_stamp.timestamp;
                            r_iv           <= '0;
                            r_close        <= 1'b0;
                            r_elapsed      <= '0;
                            r_state        <= S_FIN;
                        end
                    end
                end
                S_PREP: begin
                    r_iv         <= w_iv;
                    r_elapsed    <= w_elapsed;
                    r_close      <= (w_elapsed >= r_window_ticks);
                    r_last_stamp <= r_ts;
                    if (r_frames != '1) begin
                        r_frames <= r_frames + 1'b1;
                    end
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_neg   <= w_d[MEAN_W];
                    r_a     <= w_d[MEAN_W] ? w_d_neg[MEAN_W-1:0] : w_d[MEAN_W-1:0];
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_mean_new <= w_mean_new;
                    r_state    <= S_D2;
                end
                S_D2: begin
                    r_b     <= w_d2[MEAN_W] ? w_d2_neg[MEAN_W-1:0] : w_d2[MEAN_W-1:0];
                    r_mean  <= r_mean_new;
                    r_state <= S_MSTART;
                end
                S_MSTART: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_spread <= w_spread_sum[SPREAD_W] ? '1 : w_spread_sum[SPREAD_W-1:0];
                    if (r_iv < r_least) begin
                        r_least <= r_iv;
                    end
                    if (r_iv > r_greatest) begin
                        r_greatest <= r_iv;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // Load the result once the output register is free.
                    if (w_out_free) begin
                        r_out.frame_interval <= r_iv;
                        r_out.window_done    <= r_close;
                        r_out.window_frames  <= r_close ? r_frames : '0;
                        r_out.window_elapsed <= r_close ? r_elapsed : '0;
                        r_out.mean_interval  <= r_close ? r_mean : '0;
                        r_out.spread_sum     <= r_close ? r_spread : '0;
                        r_out.min_interval   <= r_close ? r_least : '0;
                        r_out.max_interval   <= r_close ? r_greatest : '0;
                        if (r_close) begin
                            r_window_start <= r_ts;
                            r_frames       <= '0;
                            r_mean         <= '0;
                            r_spread       <= '0;
                            r_least        <= '1;
                            r_greatest     <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Channel outputs.
    assign i_stamp.ready           = (r_state == S_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.frame_interval = r_out.frame_interval;
    assign o_result.window_done    = r_out.window_done;
    assign o_result.window_frames  = r_out.window_frames;
    assign o_result.window_elapsed = r_out.window_elapsed;
    assign o_result.mean_interval  = r_out.mean_interval;
    assign o_result.spread_sum     = r_out.spread_sum;
    assign o_result.min_interval   = r_out.min_interval;
    assign o_result.max_interval   = r_out.max_interval;

endmodule
